@@ hw/rtl/dns_name_label_encoder_unit_macros.svh @@
// Assertion helpers shared by the encoder modules.
// Each module that asserts has clk and rst_n in scope.
`ifndef DNS_NAME_LABEL_ENCODER_UNIT_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DNLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dnle: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DNLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnle: next-cycle check failed");

`endif

@@ hw/rtl/dnle_pkg.sv @@
`timescale 1ns / 1ps

package dnle_pkg;

  // Default longest label, and width of a label character count
  localparam int MAX_LABEL_DEF = 62;
  localparam int CNT_W         = 6;

  localparam logic [7:0] SEP_CHAR  = 8'h2E;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  // One job for the back end: an optional label flush and an optional terminator
  typedef struct packed {
    logic             has_label;
    logic             bank;
    logic [CNT_W-1:0] cnt;
    logic             err;
    logic             term;
  } cmd_t;

  // Back end hands a label bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEN,
    BK_RD,
    BK_DATA,
    BK_TERM
  } bk_state_t;

endpackage

@@ hw/rtl/dnle_ram.sv @@
`timescale 1ns / 1ps

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 124
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/dnle_cmdq.sv @@
`timescale 1ns / 1ps
`include "dns_name_label_encoder_unit_macros.svh"

module dnle_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dnle_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output dnle_pkg::cmd_t  head,
  output logic            full,
  output logic            empty
);

  dnle_pkg::cmd_t slot_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store a pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  assign head  = slot_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  `DNLE_ASSERT_IMP(a_no_push_full, push, !full)
  `DNLE_ASSERT_IMP(a_no_pop_empty, pop, !empty)

endmodule

@@ hw/rtl/dnle_front.sv @@
`timescale 1ns / 1ps
`include "dns_name_label_encoder_unit_macros.svh"

module dnle_front #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
  parameter int AW        = $clog2(2 * dnle_pkg::MAX_LABEL_DEF)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  input  logic                 q_full,
  output logic                 q_push,
  output dnle_pkg::cmd_t       q_cmd,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  input  dnle_pkg::release_t   rel
);

  localparam int CW = dnle_pkg::CNT_W;

  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          err_r, err_nxt;

  logic          acc;
  logic          is_sep;
  logic          cnt_zero;
  logic          cnt_full;
  logic          store;
  logic          err_step;
  logic [CW-1:0] cnt_step;
  logic          has_label;

  // Classify the character, drive in_ready and the label memory write, and build the back-end job
  always_comb begin
    is_sep    = (in_ch == dnle_pkg::SEP_CHAR);
    cnt_zero  = (cnt_r == '0);
    cnt_full  = (cnt_r == CW'(MAX_LABEL));
    in_ready  = !q_full && !busy_r[bank_r];
    acc       = in_valid && in_ready;
    store     = !is_sep && !cnt_full;
    err_step  = err_r | (is_sep & cnt_zero) | (!is_sep & cnt_full);
    cnt_step  = store ? cnt_r + CW'(1) : cnt_r;
    has_label = is_sep ? !cnt_zero : 1'b1;

    q_push = acc && ((is_sep && !cnt_zero) || in_last);
    q_cmd  = '{has_label: has_label, bank: bank_r, cnt: cnt_step,
               err: err_step, term: in_last};

    wr_en   = acc && store;
    wr_addr = AW'(cnt_r) + (bank_r ? AW'(MAX_LABEL) : '0);
    wr_data = in_ch;
  end

  // Track bank ownership, label count and the sticky error
  always_comb begin
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (acc) begin
      if (q_push && has_label) begin
        busy_nxt[bank_r] = 1'b1;
        bank_nxt         = ~bank_r;
        cnt_nxt          = '0;
      end else begin
        cnt_nxt = cnt_step;
      end
      err_nxt = err_step;
      if (in_last) begin
        cnt_nxt = '0;
        err_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      busy_r <= 2'b00;
      cnt_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

  `DNLE_ASSERT_NXT(a_bank_flip, q_push && q_cmd.has_label, bank_r != $past(bank_r))
  `DNLE_ASSERT_IMP(a_release_owned, rel.valid, busy_r[rel.bank])

endmodule

@@ hw/rtl/dnle_back.sv @@
`timescale 1ns / 1ps
`include "dns_name_label_encoder_unit_macros.svh"

module dnle_back #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
  parameter int AW        = $clog2(2 * dnle_pkg::MAX_LABEL_DEF)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  dnle_pkg::cmd_t       q_head,
  output logic                 q_pop,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [7:0]           rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_error,
  output logic                 out_end_of_name,
  output dnle_pkg::release_t   rel
);

  localparam int CW = dnle_pkg::CNT_W;

  dnle_pkg::bk_state_t state_r, state_nxt;
  dnle_pkg::cmd_t      cur_r, cur_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                ov_r, ov_nxt;
  logic [7:0]          ob_r, ob_nxt;
  logic                oe_r, oe_nxt;
  logic                oeon_r, oeon_nxt;
  logic                slot_free;

  // Sequence length byte, label bytes and terminator
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    oe_nxt    = oe_r;
    oeon_nxt  = oeon_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rel       = '0;
    slot_free = !ov_r || out_ready;
    rd_addr   = AW'(idx_r) + (cur_r.bank ? AW'(MAX_LABEL) : '0);

    case (state_r)
      dnle_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          state_nxt = q_head.has_label ? dnle_pkg::BK_LEN : dnle_pkg::BK_TERM;
        end
      end
      dnle_pkg::BK_LEN: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = 8'(cur_r.cnt);
          oe_nxt    = cur_r.err;
          oeon_nxt  = 1'b0;
          idx_nxt   = '0;
          state_nxt = dnle_pkg::BK_RD;
        end
      end
      dnle_pkg::BK_RD: begin
        rd_en     = 1'b1;
        state_nxt = dnle_pkg::BK_DATA;
      end
      dnle_pkg::BK_DATA: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = rd_data;
          oe_nxt   = cur_r.err;
          oeon_nxt = 1'b0;
          if (idx_r == cur_r.cnt - CW'(1)) begin
            rel       = '{valid: 1'b1, bank: cur_r.bank};
            state_nxt = cur_r.term ? dnle_pkg::BK_TERM : dnle_pkg::BK_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = dnle_pkg::BK_RD;
          end
        end
      end
      dnle_pkg::BK_TERM: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = dnle_pkg::TERM_BYTE;
          oe_nxt    = cur_r.err;
          oeon_nxt  = 1'b1;
          state_nxt = dnle_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = dnle_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dnle_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    ob_r   <= ob_nxt;
    oe_r   <= oe_nxt;
    oeon_r <= oeon_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_error       = oe_r;
  assign out_end_of_name = oeon_r;

  `DNLE_ASSERT_IMP(a_rel_from_data, rel.valid,
                   state_r == dnle_pkg::BK_DATA && cur_r.has_label)
  `DNLE_ASSERT_IMP(a_len_has_label, state_r == dnle_pkg::BK_LEN, cur_r.has_label)

endmodule

@@ hw/rtl/dns_name_label_encoder_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                       Role
// in        in_valid/in_ready, in_ch, in_last           one name character per transfer
// out       out_valid/out_ready, out_byte, out_error,   one wire-format byte per transfer
//           out_end_of_name
//
// The front end takes one character per cycle into one of two label banks of the
// label memory; it stalls only when the bank it fills is still being read out or
// the two-entry job queue is full.
// The back end sends a length byte from BK_LEN, each label byte by a memory read
// (BK_RD) then an output load (BK_DATA), and the terminator from BK_TERM; jobs start
// in BK_IDLE. The memory read sets the pace: no byte is read before the last is loaded.
// Reset is synchronous, active low, and needs no clearing pass.

module dns_name_label_encoder_unit #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_error,
  output logic       out_end_of_name
);

  localparam int DEPTH = 2 * MAX_LABEL;
  localparam int AW    = $clog2(DEPTH);

  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  dnle_pkg::cmd_t     q_cmd;
  dnle_pkg::cmd_t     q_head;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  dnle_pkg::release_t rel;

  dnle_front #(
    .MAX_LABEL(MAX_LABEL),
    .AW       (AW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ch   (in_ch),
    .in_last (in_last),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rel     (rel)
  );

  dnle_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_label_mem (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  dnle_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  dnle_back #(
    .MAX_LABEL(MAX_LABEL),
    .AW       (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_error      (out_error),
    .out_end_of_name(out_end_of_name),
    .rel            (rel)
  );

endmodule

@@ bench/dns_name_label_encoder_unit_tb.sv @@
`timescale 1ns / 1ps

module dns_name_label_encoder_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 50;

  // One name character waiting to be driven
  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         gap_max;
    bit         hold;
  } name_char_t;

  // One wire-format byte expected on the result channel
  typedef struct {
    logic [7:0] octet;
    logic       err;
    logic       eon;
  } wire_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_error;
  logic       out_end_of_name;

  name_char_t char_q[$];
  wire_byte_t wire_q[$];
  logic [7:0] name_buf[$];

  // Encoder shadow state
  logic [7:0] label_buf[dnle_pkg::MAX_LABEL_DEF];
  int         lbl_cnt = 0;
  logic       name_err = 1'b0;

  logic       in_took = 1'b0;
  logic       out_took = 1'b0;
  int         tx_gap = 0;
  int         rx_wait = 0;
  int         rx_count = 0;
  int         chars_total = 0;
  int         chars_taken = 0;
  int         errors = 0;
  int         cycles = 0;
  name_char_t next_char;
  wire_byte_t want;

  dns_name_label_encoder_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_error       (out_error),
    .out_end_of_name (out_end_of_name)
  );

  always #5 clk = ~clk;

  // Append one wire byte to the expected stream
  function automatic void push_wire(input logic [7:0] octet, input logic eon);
    wire_byte_t w;
    w.octet = octet;
    w.err = name_err;
    w.eon = eon;
    wire_q.push_back(w);
  endfunction

  // Emit the buffered label: length byte, then its characters
  function automatic void flush_label();
    push_wire(8'(lbl_cnt), 1'b0);
    for (int i = 0; i < lbl_cnt; i++) push_wire(label_buf[i], 1'b0);
    lbl_cnt = 0;
  endfunction

  // Advance the encoder shadow by one accepted character
  function automatic void encode_char(input logic [7:0] ch, input logic last);
    if (ch == dnle_pkg::SEP_CHAR) begin
      if (lbl_cnt == 0) name_err = 1'b1;
      else flush_label();
    end else begin
      if (lbl_cnt < dnle_pkg::MAX_LABEL_DEF) begin
        label_buf[lbl_cnt] = ch;
        lbl_cnt++;
      end else begin
        name_err = 1'b1;
      end
      if (last) flush_label();
    end
    if (last) begin
      push_wire(dnle_pkg::TERM_BYTE, 1'b1);
      lbl_cnt = 0;
      name_err = 1'b0;
    end
  endfunction

  // Queue the bytes of name_buf as one name, last flag on the final byte
  task automatic queue_name(input int gap_max, input bit hold);
    name_char_t c;
    for (int i = 0; i < name_buf.size(); i++) begin
      c.ch = name_buf[i];
      c.last = (i == name_buf.size() - 1);
      c.gap_max = gap_max;
      c.hold = hold && (i == 0);
      char_q.push_back(c);
    end
    chars_total += name_buf.size();
  endtask

  task automatic load_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // Mostly hostname characters, sometimes any byte other than the separator
  function automatic logic [7:0] label_char();
    string alnum = "abcdefghijklmnopqrstuvwxyz0123456789-";
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      c = 8'($urandom_range(0, 255));
      if (c == dnle_pkg::SEP_CHAR) c = 8'h2D;
    end else begin
      c = alnum[$urandom_range(0, alnum.len() - 1)];
    end
    return c;
  endfunction

  // Build a random name: mostly well-formed, some with stray dots, some raw noise
  task automatic build_random_name();
    int kind;
    int nlab;
    int len;
    kind = int'($urandom_range(0, 9));
    name_buf.delete();
    if (kind == 0) begin
      len = int'($urandom_range(1, 8));
      repeat (len) name_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      nlab = int'($urandom_range(1, 4));
      for (int l = 0; l < nlab; l++) begin
        if (l != 0) name_buf.push_back(dnle_pkg::SEP_CHAR);
        if ($urandom_range(0, 39) == 0) len = int'($urandom_range(58, 64));
        else len = int'($urandom_range(1, 10));
        repeat (len) name_buf.push_back(label_char());
      end
      // trailing dot now and then
      if ($urandom_range(0, 4) == 0) name_buf.push_back(dnle_pkg::SEP_CHAR);
      // stray dot: leading, doubled or splitting a label
      if (kind == 1) begin
        name_buf.insert(int'($urandom_range(0, name_buf.size() - 1)), dnle_pkg::SEP_CHAR);
      end
    end
  endtask

  // Stimulus, then drain and report
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_text("a");    queue_name(5, 1'b0);
    load_text(".");    queue_name(5, 1'b0);
    load_text(".ab");  queue_name(0, 1'b0);
    load_text("x..y"); queue_name(5, 1'b0);
    load_text("ab.");  queue_name(0, 1'b1);
    load_text("q..");  queue_name(5, 1'b0);
    // zero byte and all-ones byte as label characters
    name_buf.delete();
    name_buf.push_back(8'h00);
    name_buf.push_back(8'hFF);
    name_buf.push_back(8'h80);
    name_buf.push_back(dnle_pkg::SEP_CHAR);
    name_buf.push_back(8'h01);
    queue_name(5, 1'b0);

    // Overlong label ending the name: full label plus two dropped characters
    name_buf.delete();
    repeat (dnle_pkg::MAX_LABEL_DEF + 2) name_buf.push_back(label_char());
    queue_name(5, 1'b1);

    begin : random_names
      int stop_at;
      bit first;
      stop_at = 170;
      first = 1'b1;
      while (chars_total < stop_at) begin
        build_random_name();
        queue_name(($urandom_range(0, 3) == 0) ? 0 : 5,
                   first || ($urandom_range(0, 9) == 0));
        first = 1'b0;
      end
    end

    while (chars_taken != chars_total) @(posedge clk);
    while (wire_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sender: present the next character, hold it until the transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (char_q.size() != 0 && !(char_q[0].hold && wire_q.size() != 0)) begin
        next_char = char_q.pop_front();
        in_valid <= 1'b1;
        in_ch <= next_char.ch;
        in_last <= next_char.last;
        tx_gap = int'($urandom_range(0, next_char.gap_max));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: may stall before each transfer, but not during the first of every three runs of 80 transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        rx_wait = ((rx_count / 80) % 3 == 0) ? 0 : int'($urandom_range(0, 5));
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      out_took <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        encode_char(in_ch, in_last);
        chars_taken++;
      end
      if (out_valid && out_ready) begin
        rx_count++;
        if (wire_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h error %0b end %0b", $time,
                   out_byte, out_error, out_end_of_name);
          errors++;
        end else begin
          want = wire_q.pop_front();
          if (out_byte !== want.octet) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.octet, out_byte);
            errors++;
          end
          if (out_error !== want.err) begin
            $display("%0t: out_error expected %0b got %0b", $time, want.err, out_error);
            errors++;
          end
          if (out_end_of_name !== want.eon) begin
            $display("%0t: out_end_of_name expected %0b got %0b", $time, want.eon,
                     out_end_of_name);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
